### rtl/smp_pkg.sv
package smp_pkg;

    localparam logic [11:0] MODE_MASK  = 12'o7777;
    localparam logic [11:0] WHO_ALL    = 12'o7777;
    localparam logic [11:0] WHO_USER   = 12'o4700;
    localparam logic [11:0] WHO_GROUP  = 12'o2070;
    localparam logic [11:0] WHO_OTHER  = 12'o1007;
    localparam logic [11:0] PERM_READ  = 12'o0444;
    localparam logic [11:0] PERM_WRITE = 12'o0222;
    localparam logic [11:0] PERM_EXEC  = 12'o0111;
    localparam logic [11:0] PERM_SETID = 12'o6000;
    localparam logic [11:0] PERM_STICK = 12'o1000;
    localparam logic [12:0] OCTAL_CAP  = 13'd4096;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;
    localparam logic [1:0] OP_SET  = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OCTAL    = 3'd1;
    localparam logic [2:0] ERR_WHO      = 3'd2;
    localparam logic [2:0] ERR_NO_OP    = 3'd3;
    localparam logic [2:0] ERR_BAD_PERM = 3'd4;

    typedef struct packed {
        logic [7:0]  character;
        logic [11:0] initial_mode;
    } char_req_t;

    typedef struct packed {
        logic [11:0] final_mode;
        logic [2:0]  error;
    } mode_req_t;

    typedef struct packed {
        logic [11:0] current_mode;
        logic        in_action_part;
        logic [11:0] who_mask;
        logic [1:0]  pending_operator;
        logic [11:0] pending_permissions;
        logic [12:0] octal_value;
        logic        all_octal_digits;
        logic        at_string_start;
        logic        clause_is_empty;
        logic        after_comma;
        logic [2:0]  first_error;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        current_mode:        12'd0,
        in_action_part:      1'b0,
        who_mask:            12'd0,
        pending_operator:    OP_NONE,
        pending_permissions: 12'd0,
        octal_value:         13'd0,
        all_octal_digits:    1'b1,
        at_string_start:     1'b1,
        clause_is_empty:     1'b1,
        after_comma:         1'b0,
        first_error:         ERR_NONE
    };

endpackage

### rtl/symbolic_mode_parser_unit.sv
// channel | direction | handshake           | payload
// char    | in        | char_valid/char_stall | char_req_t {character, initial_mode}
// mode    | out       | mode_valid/mode_stall | mode_req_t {final_mode, error}
//
// One character per cycle while no terminator waits on a stalled result: a request
// is held in the input register, is decoded against the parse state and updates it in the same cycle.
// A NUL request writes the result register; from accept it passes the input register, then the result register.
// Only a NUL request waits on a stalled result; other held characters always move on, but new input stalls behind it.
// Reset (rst_n low, async) clears the parse state and both valid flags.
module symbolic_mode_parser_unit
    import smp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  char_req_t char_data,
    output logic      mode_valid,
    input  logic      mode_stall,
    output mode_req_t mode_data
);

    logic         hold_valid;
    char_req_t    hold_data;
    logic         advance;
    logic         is_end;
    parse_state_t state_reg;
    parse_state_t state_next;
    mode_req_t    result;
    logic         mode_valid_reg;
    logic         mode_valid_next;
    mode_req_t    mode_data_reg;
    logic         out_free;

    smp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .take       (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    smp_step u_step (
        .state      (state_reg),
        .item       (hold_data),
        .state_next (state_next),
        .is_end     (is_end),
        .result     (result)
    );

    // result register is free when empty or being drained this cycle
    assign out_free = !mode_valid_reg || !mode_stall;
    // plain characters always move; a terminator needs room for its result
    assign advance  = hold_valid && (!is_end || out_free);

    always_comb
    begin
        if (advance && is_end)
        begin
            mode_valid_next = 1'b1;
        end
        else if (!mode_stall)
        begin
            mode_valid_next = 1'b0;
        end
        else
        begin
            mode_valid_next = mode_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            mode_valid_reg <= 1'b0;
        end
        else
        begin
            mode_valid_reg <= mode_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_end)
        begin
            mode_data_reg <= result;
        end
    end

    assign mode_valid = mode_valid_reg;
    assign mode_data  = mode_data_reg;

    // an error result never carries a mode
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_valid && (mode_data.error != ERR_NONE) |-> mode_data.final_mode == 12'd0)
        else $error("error result with nonzero mode");

    // error code stays in its defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_valid |-> mode_data.error <= ERR_BAD_PERM)
        else $error("error code out of range");

    // a result appears only after a terminator was consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mode_valid) |-> $past(advance && is_end))
        else $error("result without terminator");

    // consuming a terminator returns the parser to string start
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> state_reg.at_string_start && state_reg.all_octal_digits)
        else $error("state not cleared after terminator");

    // input side stalls only when a request is held and blocked on the result
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> hold_valid && is_end && mode_valid && mode_stall)
        else $error("unexpected input stall");

endmodule

### rtl/smp_in_stage.sv
module smp_in_stage
    import smp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  char_req_t char_data,
    input  logic      take,
    output logic      hold_valid,
    output char_req_t hold_data
);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    char_req_t hold_data_reg;
    logic      accept;

    // stall only while a held request cannot move on this cycle
    assign char_stall = hold_valid_reg && !take;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (take)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_data_reg <= char_data;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_data  = hold_data_reg;

endmodule

### rtl/smp_step.sv
module smp_step
    import smp_pkg::*;
(
    input  parse_state_t state,
    input  char_req_t    item,
    output parse_state_t state_next,
    output logic         is_end,
    output mode_req_t    result
);

    function automatic logic [11:0] apply_op(
        input logic [11:0] mode,
        input logic [11:0] who,
        input logic [11:0] perms,
        input logic [1:0]  op
    );
        logic [11:0] sel;
        logic [11:0] res;
        sel = who & perms;
        unique case (op)
            OP_ADD:  res = mode | sel;
            OP_SUB:  res = mode & ~sel;
            OP_SET:  res = sel | (~who & mode);
            default: res = mode;
        endcase
        return res;
    endfunction

    logic [7:0]   c;
    logic [11:0]  cur;
    logic [1:0]   op;
    logic [15:0]  oct_wide;
    logic [11:0]  m;
    logic         is_digit;
    parse_state_t s;

    assign c      = item.character;
    assign is_end = (c == 8'd0);

    always_comb
    begin
        s        = state;
        cur      = state.at_string_start ? (item.initial_mode & MODE_MASK)
                                         : state.current_mode;
        s.current_mode    = cur;
        s.at_string_start = 1'b0;
        result            = '{final_mode: 12'd0, error: ERR_NONE};
        m                 = 12'd0;
        is_digit          = (c >= 8'h30) && (c <= 8'h37);
        oct_wide          = {state.octal_value, 3'b000} + {13'd0, c[2:0]};

        unique case (c)
            8'h2b:   op = OP_ADD;
            8'h2d:   op = OP_SUB;
            8'h3d:   op = OP_SET;
            default: op = OP_NONE;
        endcase

        if (!is_end)
        begin
            if (state.all_octal_digits && is_digit)
            begin
                s.octal_value = (oct_wide > {3'd0, OCTAL_CAP}) ? OCTAL_CAP
                                                               : oct_wide[12:0];
            end
            else
            begin
                s.all_octal_digits = 1'b0;
            end

            if (state.first_error == ERR_NONE)
            begin
                if (state.in_action_part)
                begin
                    if (op != OP_NONE)
                    begin
                        if (state.pending_operator != OP_NONE)
                        begin
                            s.current_mode = apply_op(cur, state.who_mask,
                                                      state.pending_permissions,
                                                      state.pending_operator);
                            s.pending_permissions = 12'd0;
                        end
                        s.pending_operator = op;
                    end
                    else
                    begin
                        unique case (c)
                            8'h72: s.pending_permissions |= PERM_READ;   // r
                            8'h77: s.pending_permissions |= PERM_WRITE;  // w
                            8'h78: s.pending_permissions |= PERM_EXEC;   // x
                            8'h58:                                       // X
                            begin
                                if ((cur & PERM_EXEC) != 12'd0)
                                begin
                                    s.pending_permissions |= PERM_EXEC;
                                end
                            end
                            8'h73: s.pending_permissions |= PERM_SETID;  // s
                            8'h74: s.pending_permissions |= PERM_STICK;  // t
                            8'h75:                                       // u copy
                            begin
                                m = cur & 12'o0700;
                                s.pending_permissions |= m | (m >> 3) | (m >> 6);
                            end
                            8'h67:                                       // g copy
                            begin
                                m = cur & 12'o0070;
                                s.pending_permissions |= (m << 3) | m | (m >> 3);
                            end
                            8'h6f:                                       // o copy
                            begin
                                m = cur & 12'o0007;
                                s.pending_permissions |= (m << 6) | (m << 3) | m;
                            end
                            8'h2c:                                       // comma
                            begin
                                s.current_mode = apply_op(cur, state.who_mask,
                                                          state.pending_permissions,
                                                          state.pending_operator);
                                s.pending_permissions = 12'd0;
                                s.pending_operator    = OP_NONE;
                                s.in_action_part      = 1'b0;
                                s.who_mask            = 12'd0;
                                s.clause_is_empty     = 1'b1;
                                s.after_comma         = 1'b1;
                            end
                            default: s.first_error = ERR_BAD_PERM;
                        endcase
                    end
                end
                else
                begin
                    s.clause_is_empty = 1'b0;
                    s.after_comma     = 1'b0;
                    if (op != OP_NONE)
                    begin
                        if (state.who_mask == 12'd0)
                        begin
                            s.who_mask = WHO_ALL;
                        end
                        s.in_action_part      = 1'b1;
                        s.pending_operator    = op;
                        s.pending_permissions = 12'd0;
                    end
                    else
                    begin
                        unique case (c)
                            8'h61:   s.who_mask = state.who_mask | WHO_ALL;
                            8'h75:   s.who_mask = state.who_mask | WHO_USER;
                            8'h67:   s.who_mask = state.who_mask | WHO_GROUP;
                            8'h6f:   s.who_mask = state.who_mask | WHO_OTHER;
                            default: s.first_error = ERR_WHO;
                        endcase
                    end
                end
            end
            state_next = s;
        end
        else
        begin
            if (state.all_octal_digits)
            begin
                if (state.octal_value > {1'b0, MODE_MASK})
                begin
                    result.error = ERR_OCTAL;
                end
                else
                begin
                    result.final_mode = state.octal_value[11:0];
                end
            end
            else if (state.first_error != ERR_NONE)
            begin
                result.error = state.first_error;
            end
            else if (state.in_action_part)
            begin
                result.final_mode = apply_op(cur, state.who_mask,
                                             state.pending_permissions,
                                             state.pending_operator);
            end
            else if (state.after_comma && state.clause_is_empty)
            begin
                result.final_mode = cur;
            end
            else
            begin
                result.error = ERR_NO_OP;
            end
            state_next = STATE_RESET;
        end
    end

endmodule
